// ===== sv/linear_chirp_sample_generator_unit_defines.svh =====
// Assertion macros for the linear chirp sample generator
`ifndef LINEAR_CHIRP_SAMPLE_GENERATOR_UNIT_DEFINES_SVH
`define LINEAR_CHIRP_SAMPLE_GENERATOR_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LCSG_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LCSG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/lcsg_pkg.sv =====
// Shared types, constants and helpers for the linear chirp sample generator
package lcsg_pkg;

    // default sizes
    localparam int DEF_TABLE_POINTS   = 8;
    localparam int DEF_MAX_CHANNELS   = 8;
    localparam int DEF_PHASE_BITS     = 32;
    localparam int DEF_SINE_ADDR_BITS = 10;

    // shared arithmetic widths
    localparam int MUL_W     = 32;
    localparam int DIV_DVD_W = 56;
    localparam int DIV_DVS_W = 32;

    // sine polynomial coefficients, Q30
    localparam logic [31:0] C1 = 32'd1686629713;
    localparam logic [31:0] C3 = 32'd693598668;
    localparam logic [31:0] C5 = 32'd85569306;
    localparam logic [31:0] C7 = 32'd5026995;
    localparam logic [31:0] C9 = 32'd172272;
    localparam logic [31:0] Q30_ONE = 32'h4000_0000;

    // request kinds
    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_POINT   = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    // sample formats
    localparam logic [1:0] FMT_U8  = 2'd0;
    localparam logic [1:0] FMT_S16 = 2'd1;
    localparam logic [1:0] FMT_S32 = 2'd2;

    // register indexes
    localparam logic [2:0] REG_START_STEP    = 3'd0;
    localparam logic [2:0] REG_STEP_DELTA    = 3'd1;
    localparam logic [2:0] REG_TOTAL_SAMPLES = 3'd2;
    localparam logic [2:0] REG_FADE_SAMPLES  = 3'd3;
    localparam logic [2:0] REG_SAMPLE_FORMAT = 3'd4;
    localparam logic [2:0] REG_CHANNEL_COUNT = 3'd5;
    localparam logic [2:0] REG_POINT_COUNT   = 3'd6;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  point_index;
        logic [31:0] point_step;
        logic [15:0] point_gain;
    } lcsg_in_t;

    typedef struct packed {
        logic signed [31:0] sample;
        logic [2:0]         channel;
        logic               last;
        logic               finished;
    } lcsg_out_t;

    typedef struct packed {
        logic busy;
        logic done;
    } lcsg_div_stat_t;

    // Horner coefficients after the innermost one
    function automatic logic [31:0] poly_coef(input logic [1:0] idx);
        logic [31:0] c;
        case (idx)
            2'd0:    c = C7;
            2'd1:    c = C5;
            2'd2:    c = C3;
            default: c = C1;
        endcase
        return c;
    endfunction

endpackage

// ===== sv/linear_chirp_sample_generator_unit.sv =====
// Linear chirp sine generator with gain envelope, fades and channel fan-out
//
//   port group | dir | handshake         | payload
//   s_*        | in  | s_valid / s_ready | lcsg_in_t  (kind, point_index, point_step, point_gain)
//   m_*        | out | m_valid / m_ready | lcsg_out_t (sample, channel, last, finished)
//   p*         | cfg | psel / penable    | 32-bit APB registers at 4*index
//
// A point write, restart or unknown request is handled at its accept. A live tick runs the
// sine polynomial on the shared multiplier and the breakpoint scan, and waits on the shared
// 56-step divider for the gain slope and the fade, before the first result. A tick that
// needs no interpolation skips the gain divide. Then one result per channel, one per
// cycle while m_ready allows. A finished tick goes straight to emitting its results.
// Reset is synchronous and active low; the breakpoint table is not cleared.
// s_ready is high only while the sequencer is idle; m_ready low holds the output.
`include "linear_chirp_sample_generator_unit_defines.svh"

module linear_chirp_sample_generator_unit import lcsg_pkg::*; #(
    parameter int TABLE_POINTS   = DEF_TABLE_POINTS,
    parameter int MAX_CHANNELS   = DEF_MAX_CHANNELS,
    parameter int PHASE_BITS     = DEF_PHASE_BITS,
    parameter int SINE_ADDR_BITS = DEF_SINE_ADDR_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  lcsg_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output lcsg_out_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PB    = PHASE_BITS;
    localparam int SA    = SINE_ADDR_BITS;
    localparam int PT_W  = $clog2(TABLE_POINTS);
    localparam int NP_W  = $clog2(TABLE_POINTS + 1);
    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int NC_W  = $clog2(MAX_CHANNELS + 1);
    localparam int CMP_W = (PB > 32) ? PB : 32;

    // sequencer states
    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_SQ   = 5'd1;
    localparam logic [4:0] ST_SQW  = 5'd2;
    localparam logic [4:0] ST_PM   = 5'd3;
    localparam logic [4:0] ST_PS   = 5'd4;
    localparam logic [4:0] ST_XM   = 5'd5;
    localparam logic [4:0] ST_XW   = 5'd6;
    localparam logic [4:0] ST_G0   = 5'd7;
    localparam logic [4:0] ST_GL   = 5'd8;
    localparam logic [4:0] ST_GS   = 5'd9;
    localparam logic [4:0] ST_GI   = 5'd10;
    localparam logic [4:0] ST_GP   = 5'd11;
    localparam logic [4:0] ST_GQ   = 5'd12;
    localparam logic [4:0] ST_GW   = 5'd13;
    localparam logic [4:0] ST_GM   = 5'd14;
    localparam logic [4:0] ST_GMW  = 5'd15;
    localparam logic [4:0] ST_FM   = 5'd16;
    localparam logic [4:0] ST_FD   = 5'd17;
    localparam logic [4:0] ST_FW   = 5'd18;
    localparam logic [4:0] ST_ENC  = 5'd19;
    localparam logic [4:0] ST_ENW  = 5'd20;
    localparam logic [4:0] ST_EMIT = 5'd21;

    // configuration registers
    logic [31:0]        start_step_reg;
    logic signed [31:0] step_delta_reg;
    logic [23:0]        total_reg;
    logic [23:0]        fade_reg;
    logic [1:0]         fmt_reg;
    logic [3:0]         chcnt_reg;
    logic [3:0]         pcnt_reg;

    // sweep state
    logic [4:0]    state_reg, state_next;
    logic [23:0]   sidx_reg;
    logic [PB-1:0] pacc_reg;
    logic [PB-1:0] pstep_reg;

    // breakpoint table
    logic [31:0] break_steps [TABLE_POINTS];
    logic [15:0] break_gains [TABLE_POINTS];

    // per-tick working registers
    logic [30:0]     x_reg;
    logic            neg_reg;
    logic [PB-1:0]   step_cur_reg;
    logic [23:0]     icur_reg;
    logic [23:0]     m_reg;
    logic [31:0]     x2_reg;
    logic [31:0]     t_reg;
    logic [1:0]      pidx_reg;
    logic [30:0]     mag_reg;
    logic [15:0]     gain_reg;
    logic [31:0]     f1_reg, f2_reg;
    logic [15:0]     g1_reg, g2_reg;
    logic [PT_W-1:0] scan_reg;
    logic [15:0]     d_reg;
    logic            up_reg;
    logic [31:0]     ds_reg, dv_reg;
    logic [31:0]     sample_reg;
    logic            fin_reg;
    logic [CH_W-1:0] chan_reg;
    logic [NC_W-1:0] nch_reg;
    logic            m_valid_reg;
    lcsg_out_t       m_data_reg;

    // shared units
    logic [MUL_W-1:0]     mul_a, mul_b;
    logic [2*MUL_W-1:0]   prod;
    logic                 div_start;
    logic [DIV_DVD_W-1:0] div_dvd;
    logic [DIV_DVS_W-1:0] div_dvs;
    logic [DIV_DVD_W-1:0] quo;
    lcsg_div_stat_t       div_stat;

    // combinational helpers
    logic            in_acc;
    logic            cfg_wr;
    logic            tick_fin;
    logic [PB-1:0]   delta_ext;
    logic [1:0]      quad;
    logic [SA-1:0]   addr;
    logic [SA:0]     rom_i;
    logic [NC_W-1:0] nch_c;
    logic [NP_W-1:0] n_cur;
    logic [PT_W-1:0] rd_idx;
    logic [31:0]     rd_step;
    logic [15:0]     rd_gain;
    logic [CMP_W-1:0] s_ext, b_ext, f1_ext;
    logic [23:0]     fl;
    logic [23:0]     fin_m, fout_m, m_c;
    logic [24:0]     i_plus_f;
    logic [31:0]     biased;
    logic [31:0]     enc_v;
    logic            emit_load, emit_last;
    logic [15:0]     g_in;

    assign in_acc  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    lcsg_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (prod)
    );

    lcsg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .quotient (quo),
        .stat     (div_stat)
    );

    // phase to quarter-wave index
    assign quad  = pacc_reg[PB-1 -: 2];
    assign addr  = pacc_reg[PB-3 -: SA];
    assign rom_i = quad[0] ? ((SA+1)'(1) << SA) - (SA+1)'(addr) : (SA+1)'(addr);
    assign delta_ext = PB'(step_delta_reg);
    assign tick_fin  = (sidx_reg >= total_reg);

    // channel and point counts, clamped
    always_comb begin
        if (chcnt_reg == 4'd0) begin
            nch_c = NC_W'(1);
        end else if (32'(chcnt_reg) > MAX_CHANNELS) begin
            nch_c = NC_W'(MAX_CHANNELS);
        end else begin
            nch_c = NC_W'(chcnt_reg);
        end
        if (32'(pcnt_reg) > TABLE_POINTS) begin
            n_cur = NP_W'(TABLE_POINTS);
        end else begin
            n_cur = NP_W'(pcnt_reg);
        end
    end

    // fade multiplier m for the current index
    always_comb begin
        fl       = (fade_reg == 24'd0) ? 24'd1 : fade_reg;
        fin_m    = (icur_reg < fl) ? icur_reg : fl;
        i_plus_f = 25'(icur_reg) + 25'(fl);
        fout_m   = (i_plus_f > 25'(total_reg)) ? total_reg - icur_reg : fl;
        m_c      = (fin_m < fout_m) ? fin_m : fout_m;
    end

    // breakpoint read port, one slot a cycle
    always_comb begin
        case (state_reg)
            ST_G0:   rd_idx = '0;
            ST_GL:   rd_idx = PT_W'(n_cur - 1'b1);
            default: rd_idx = scan_reg;
        endcase
        rd_step = break_steps[rd_idx];
        rd_gain = break_gains[rd_idx];
        s_ext   = CMP_W'(step_cur_reg);
        b_ext   = CMP_W'(rd_step);
        f1_ext  = CMP_W'(f1_reg);
    end

    // multiplier operand select
    always_comb begin
        biased = neg_reg ? Q30_ONE - 32'(mag_reg) : Q30_ONE + 32'(mag_reg);
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            ST_SQ: begin
                mul_a = 32'(x_reg);
                mul_b = 32'(x_reg);
            end
            ST_PM: begin
                mul_a = x2_reg;
                mul_b = t_reg;
            end
            ST_XM: begin
                mul_a = 32'(x_reg);
                mul_b = t_reg;
            end
            ST_GP: begin
                mul_a = 32'(d_reg);
                mul_b = ds_reg;
            end
            ST_GM: begin
                mul_a = 32'(mag_reg);
                mul_b = 32'(gain_reg);
            end
            ST_FM: begin
                mul_a = 32'(mag_reg);
                mul_b = 32'(m_reg);
            end
            ST_ENC: begin
                case (fmt_reg)
                    FMT_U8: begin
                        mul_a = biased;
                        mul_b = 32'd255;
                    end
                    FMT_S16: begin
                        mul_a = 32'(mag_reg);
                        mul_b = 32'd32767;
                    end
                    FMT_S32: begin
                        mul_a = 32'(mag_reg);
                        mul_b = 32'd2147483647;
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // divider launch: gain slope, then fade scaling
    assign div_start = (state_reg == ST_GQ) || (state_reg == ST_FD);
    assign div_dvd   = DIV_DVD_W'(prod);
    assign div_dvs   = (state_reg == ST_GQ) ? dv_reg : DIV_DVS_W'(fl);

    assign enc_v     = prod[61:30];
    assign emit_load = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
    assign emit_last = ((NC_W+1)'(chan_reg) + 1'b1) == (NC_W+1)'(nch_reg);
    assign g_in      = (s_data.point_gain > 16'd32768) ? 16'd32768 : s_data.point_gain;

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc && s_data.kind == KIND_TICK) begin
                    state_next = tick_fin ? ST_EMIT : ST_SQ;
                end
            end
            ST_SQ:  state_next = ST_SQW;
            ST_SQW: state_next = ST_PM;
            ST_PM:  state_next = ST_PS;
            ST_PS:  state_next = (pidx_reg == 2'd3) ? ST_XM : ST_PM;
            ST_XM:  state_next = ST_XW;
            ST_XW:  state_next = ST_G0;
            ST_G0: begin
                state_next = (n_cur == '0 || s_ext <= b_ext) ? ST_GM : ST_GL;
            end
            ST_GL:  state_next = (s_ext >= b_ext) ? ST_GM : ST_GS;
            ST_GS:  state_next = (s_ext < b_ext) ? ST_GI : ST_GS;
            ST_GI:  state_next = (s_ext < f1_ext) ? ST_GM : ST_GP;
            ST_GP:  state_next = ST_GQ;
            ST_GQ:  state_next = ST_GW;
            ST_GW:  state_next = div_stat.done ? ST_GM : ST_GW;
            ST_GM:  state_next = ST_GMW;
            ST_GMW: state_next = ST_FM;
            ST_FM:  state_next = ST_FD;
            ST_FD:  state_next = ST_FW;
            ST_FW:  state_next = div_stat.done ? ST_ENC : ST_FW;
            ST_ENC: state_next = ST_ENW;
            ST_ENW: state_next = ST_EMIT;
            ST_EMIT: begin
                if (emit_load && emit_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control state, sweep state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            sidx_reg       <= '0;
            pacc_reg       <= '0;
            pstep_reg      <= '0;
            start_step_reg <= '0;
            step_delta_reg <= '0;
            total_reg      <= '0;
            fade_reg       <= 24'd1;
            fmt_reg        <= FMT_S16;
            chcnt_reg      <= 4'd1;
            pcnt_reg       <= '0;
        end else begin
            state_reg <= state_next;
            if (emit_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (in_acc && s_data.kind == KIND_RESTART) begin
                sidx_reg  <= '0;
                pacc_reg  <= '0;
                pstep_reg <= PB'(start_step_reg);
            end else if (in_acc && s_data.kind == KIND_TICK && !tick_fin) begin
                sidx_reg  <= sidx_reg + 1'b1;
                pacc_reg  <= pacc_reg + pstep_reg;
                pstep_reg <= pstep_reg + delta_ext;
            end
            if (cfg_wr) begin
                case (paddr[4:2])
                    REG_START_STEP:    start_step_reg <= pwdata;
                    REG_STEP_DELTA:    step_delta_reg <= pwdata;
                    REG_TOTAL_SAMPLES: total_reg      <= pwdata[23:0];
                    REG_FADE_SAMPLES:  fade_reg       <= pwdata[23:0];
                    REG_SAMPLE_FORMAT: fmt_reg        <= pwdata[1:0];
                    REG_CHANNEL_COUNT: chcnt_reg      <= pwdata[3:0];
                    REG_POINT_COUNT:   pcnt_reg       <= pwdata[3:0];
                    default: ;
                endcase
            end
        end
    end

    // register readback
    always_comb begin
        case (paddr[4:2])
            REG_START_STEP:    prdata = start_step_reg;
            REG_STEP_DELTA:    prdata = step_delta_reg;
            REG_TOTAL_SAMPLES: prdata = 32'(total_reg);
            REG_FADE_SAMPLES:  prdata = 32'(fade_reg);
            REG_SAMPLE_FORMAT: prdata = 32'(fmt_reg);
            REG_CHANNEL_COUNT: prdata = 32'(chcnt_reg);
            REG_POINT_COUNT:   prdata = 32'(pcnt_reg);
            default:           prdata = '0;
        endcase
    end

    // breakpoint writes, gain clamped to unity
    always_ff @(posedge aclk) begin
        if (in_acc && s_data.kind == KIND_POINT && 32'(s_data.point_index) < TABLE_POINTS) begin
            break_steps[PT_W'(s_data.point_index)] <= s_data.point_step;
            break_gains[PT_W'(s_data.point_index)] <= g_in;
        end
    end

    // per-tick datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (in_acc && s_data.kind == KIND_TICK) begin
                    nch_reg      <= nch_c;
                    chan_reg     <= '0;
                    fin_reg      <= tick_fin;
                    sample_reg   <= '0;
                    x_reg        <= 31'(rom_i) << (30 - SA);
                    neg_reg      <= quad[1];
                    step_cur_reg <= pstep_reg;
                    icur_reg     <= sidx_reg;
                end
            end
            ST_SQ: m_reg <= m_c;
            ST_SQW: begin
                x2_reg   <= prod[61:30];
                t_reg    <= C9;
                pidx_reg <= '0;
            end
            ST_PS: begin
                t_reg    <= poly_coef(pidx_reg) - prod[61:30];
                pidx_reg <= pidx_reg + 1'b1;
            end
            ST_XW: begin
                mag_reg <= (prod[63:30] > 34'(Q30_ONE)) ? 31'(Q30_ONE) : prod[60:30];
            end
            ST_G0: begin
                if (n_cur == '0) begin
                    gain_reg <= 16'd32768;
                end else if (s_ext <= b_ext) begin
                    gain_reg <= rd_gain;
                end else begin
                    f1_reg <= rd_step;
                    g1_reg <= rd_gain;
                end
            end
            ST_GL: begin
                gain_reg <= rd_gain;
                scan_reg <= PT_W'(1);
            end
            ST_GS: begin
                if (s_ext < b_ext) begin
                    f2_reg <= rd_step;
                    g2_reg <= rd_gain;
                end else begin
                    f1_reg   <= rd_step;
                    g1_reg   <= rd_gain;
                    scan_reg <= scan_reg + 1'b1;
                end
            end
            ST_GI: begin
                gain_reg <= g1_reg;
                ds_reg   <= s_ext[31:0] - f1_reg;
                dv_reg   <= f2_reg - f1_reg;
                up_reg   <= (g2_reg >= g1_reg);
                d_reg    <= (g2_reg >= g1_reg) ? g2_reg - g1_reg : g1_reg - g2_reg;
            end
            ST_GW: begin
                if (div_stat.done) begin
                    gain_reg <= up_reg ? g1_reg + quo[15:0] : g1_reg - quo[15:0];
                end
            end
            ST_GMW: mag_reg <= prod[45:15];
            ST_FW: begin
                if (div_stat.done) begin
                    mag_reg <= quo[30:0];
                end
            end
            ST_ENW: begin
                case (fmt_reg)
                    FMT_U8:  sample_reg <= 32'(prod[38:31]);
                    FMT_S16: sample_reg <= neg_reg ? 32'd0 - enc_v : enc_v;
                    FMT_S32: sample_reg <= neg_reg ? 32'd0 - enc_v : enc_v;
                    default: sample_reg <= '0;
                endcase
            end
            ST_EMIT: begin
                if (emit_load) begin
                    chan_reg <= chan_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (emit_load) begin
            m_data_reg.sample   <= sample_reg;
            m_data_reg.channel  <= 3'(chan_reg);
            m_data_reg.last     <= emit_last;
            m_data_reg.finished <= fin_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // checks
    `LCSG_ASSERT_IMP(a_div_idle_start, div_start, !div_stat.busy, "divider restarted while busy")
    `LCSG_ASSERT_NEXT(a_div_runs, div_start, div_stat.busy, "divider did not start")
    `LCSG_ASSERT_IMP(a_fin_silent, m_valid && m_data.finished, m_data.sample == 0, "finished result not silent")
    `LCSG_ASSERT_IMP(a_chan_range, state_reg == ST_EMIT, (NC_W+1)'(chan_reg) < (NC_W+1)'(nch_reg), "channel past count")

endmodule

// ===== sv/lcsg_mul.sv =====
// Shared registered 32x32 unsigned multiplier
module lcsg_mul import lcsg_pkg::*; (
    input  logic                 aclk,
    input  logic [MUL_W-1:0]     a,
    input  logic [MUL_W-1:0]     b,
    output logic [2*MUL_W-1:0]   p
);

    logic [2*MUL_W-1:0] p_reg;

    // product is registered and lands in the cycle after the operands
    always_ff @(posedge aclk) begin
        p_reg <= (2*MUL_W)'(a) * (2*MUL_W)'(b);
    end

    assign p = p_reg;

endmodule

// ===== sv/lcsg_div.sv =====
// Shared restoring divider, one quotient bit per cycle
module lcsg_div import lcsg_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIV_DVD_W-1:0]  dividend,
    input  logic [DIV_DVS_W-1:0]  divisor,
    output logic [DIV_DVD_W-1:0]  quotient,
    output lcsg_div_stat_t        stat
);

    localparam int CNT_W = $clog2(DIV_DVD_W);

    logic [DIV_DVD_W-1:0] dvd_reg;
    logic [DIV_DVS_W-1:0] dvs_reg;
    logic [DIV_DVS_W-1:0] rem_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_DVS_W:0]   trial;
    logic [DIV_DVS_W:0]   diff;
    logic                 ge;

    // trial subtract of the shifted remainder
    assign trial = {rem_reg, dvd_reg[DIV_DVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = trial >= {1'b0, dvs_reg};

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: quotient bits shift in where the dividend shifts out
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DIV_DVS_W-1:0] : trial[DIV_DVS_W-1:0];
            dvd_reg <= {dvd_reg[DIV_DVD_W-2:0], ge};
        end
    end

    assign quotient  = dvd_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== tb/lcsg_checker.sv =====
// Checker for the linear chirp sample generator: predicts samples and compares outputs
`timescale 1ns / 100ps

module lcsg_checker import lcsg_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  lcsg_in_t    s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  lcsg_out_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          errors,
    output int          pending
);

    // shadow registers
    logic [31:0] start_step_r, step_delta_r;
    logic [23:0] total_r, fade_r;
    logic [1:0]  format_r;
    logic [3:0]  chan_r, points_r;

    // sweep state
    logic [23:0] sweep_idx;
    logic [31:0] phase_pos, phase_inc;
    logic [31:0] bp_step [8];
    logic [15:0] bp_gain [8];

    longint unsigned quarter_wave [1025];
    lcsg_out_t expected_samples [$];

    // quarter-wave amplitude in Q30 from the odd polynomial
    function automatic longint unsigned quarter_amp(input int k);
        longint unsigned x, x2, t, r;
        x  = longint'(k) << 20;
        x2 = (x * x) >> 30;
        t  = C9;
        t  = C7 - ((x2 * t) >> 30);
        t  = C5 - ((x2 * t) >> 30);
        t  = C3 - ((x2 * t) >> 30);
        t  = C1 - ((x2 * t) >> 30);
        r  = (x * t) >> 30;
        if (r > Q30_ONE)
            r = Q30_ONE;
        return r;
    endfunction

    initial begin
        for (int k = 0; k <= 1024; k++)
            quarter_wave[k] = quarter_amp(k);
    end

    // envelope gain for the current step, Q1.15
    function automatic longint unsigned envelope_gain(input logic [31:0] s);
        int n;
        longint unsigned f1, f2, g1, g2, d, q;
        n = (points_r > 8) ? 8 : int'(points_r);
        if (n == 0)
            return 32768;
        if (s <= bp_step[0])
            return bp_gain[0];
        if (s >= bp_step[n-1])
            return bp_gain[n-1];
        for (int i = 1; i < n; i++) begin
            if (s < bp_step[i]) begin
                f1 = bp_step[i-1];
                f2 = bp_step[i];
                g1 = bp_gain[i-1];
                g2 = bp_gain[i];
                if (s < f1)
                    return g1;
                d = (g2 >= g1) ? g2 - g1 : g1 - g2;
                q = d * (s - f1) / (f2 - f1);
                return (g2 >= g1) ? g1 + q : g1 - q;
            end
        end
        return 32768;
    endfunction

    // work out the channel results of one accepted request
    task automatic predict_request(input lcsg_in_t r);
        int nch;
        logic [31:0] smp, v;
        logic fin, neg;
        logic [11:0] top;
        int rom_i;
        longint unsigned mag, fl, biased;
        longint i, t, f, fin_m, fout_m, m;
        lcsg_out_t o;
        smp = '0;
        fin = 1'b0;
        case (r.kind)
            KIND_POINT: begin
                bp_step[r.point_index] = r.point_step;
                bp_gain[r.point_index] = (r.point_gain > 16'd32768) ? 16'd32768 : r.point_gain;
            end
            KIND_RESTART: begin
                sweep_idx = '0;
                phase_pos = '0;
                phase_inc = start_step_r;
            end
            KIND_TICK: begin
                nch = (chan_r == 0) ? 1 : ((chan_r > 8) ? 8 : int'(chan_r));
                if (sweep_idx >= total_r) begin
                    fin = 1'b1;
                end else begin
                    top   = phase_pos[31:20];
                    rom_i = top[10] ? 1024 - int'(top[9:0]) : int'(top[9:0]);
                    neg   = top[11];
                    mag   = quarter_wave[rom_i];
                    fl    = (fade_r == 0) ? 1 : fade_r;
                    i = sweep_idx;
                    t = total_r;
                    f = fl;
                    fin_m  = (i < f) ? i : f;
                    fout_m = (i > t - f) ? t - i : f;
                    m = (fin_m < fout_m) ? fin_m : fout_m;
                    mag = (mag * envelope_gain(phase_inc)) >> 15;
                    mag = mag * longint'(m) / fl;
                    case (format_r)
                        FMT_U8: begin
                            biased = neg ? Q30_ONE - mag : Q30_ONE + mag;
                            smp = (biased * 255) >> 31;
                        end
                        FMT_S16: begin
                            v = (mag * 32767) >> 30;
                            smp = neg ? -v : v;
                        end
                        FMT_S32: begin
                            v = (mag * 64'd2147483647) >> 30;
                            smp = neg ? -v : v;
                        end
                        default: smp = '0;
                    endcase
                    phase_pos = phase_pos + phase_inc;
                    phase_inc = phase_inc + step_delta_r;
                    sweep_idx = sweep_idx + 24'd1;
                end
                for (int c = 0; c < nch; c++) begin
                    o.sample   = smp;
                    o.channel  = c[2:0];
                    o.last     = (c + 1 == nch);
                    o.finished = fin;
                    expected_samples.push_back(o);
                end
            end
            default: ;
        endcase
    endtask

    // compare one output against the oldest expectation
    task automatic check_output(input lcsg_out_t a);
        lcsg_out_t e;
        if (expected_samples.size() == 0) begin
            $display("%0t: unexpected output sample=%0d channel=%0d", $time, a.sample, a.channel);
            errors++;
        end else begin
            e = expected_samples.pop_front();
            if (a.sample !== e.sample) begin
                $display("%0t: sample exp %0d got %0d", $time, e.sample, a.sample);
                errors++;
            end
            if (a.channel !== e.channel) begin
                $display("%0t: channel exp %0d got %0d", $time, e.channel, a.channel);
                errors++;
            end
            if (a.last !== e.last) begin
                $display("%0t: last exp %0b got %0b", $time, e.last, a.last);
                errors++;
            end
            if (a.finished !== e.finished) begin
                $display("%0t: finished exp %0b got %0b", $time, e.finished, a.finished);
                errors++;
            end
        end
    endtask

    initial errors = 0;

    // observe register writes, requests and outputs
    always @(posedge aclk) begin
        if (!aresetn) begin
            start_step_r <= '0;
            step_delta_r <= '0;
            total_r      <= '0;
            fade_r       <= 24'd1;
            format_r     <= FMT_S16;
            chan_r       <= 4'd1;
            points_r     <= '0;
            sweep_idx    <= '0;
            phase_pos    <= '0;
            phase_inc    <= '0;
            expected_samples.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_START_STEP:    start_step_r = pwdata;
                    REG_STEP_DELTA:    step_delta_r = pwdata;
                    REG_TOTAL_SAMPLES: total_r      = pwdata[23:0];
                    REG_FADE_SAMPLES:  fade_r       = pwdata[23:0];
                    REG_SAMPLE_FORMAT: format_r     = pwdata[1:0];
                    REG_CHANNEL_COUNT: chan_r       = pwdata[3:0];
                    REG_POINT_COUNT:   points_r     = pwdata[3:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                predict_request(s_data);
            if (m_valid && m_ready)
                check_output(m_data);
        end
        pending <= expected_samples.size();
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the linear chirp sample generator: stimulus and verdict
`timescale 1ns / 100ps

module tb;
    import lcsg_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    lcsg_in_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    lcsg_out_t   m_data;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          errors, pending;
    bit          quiet = 1'b0;
    int          sink_hold = 0;

    always #5 aclk = ~aclk;

    linear_chirp_sample_generator_unit uut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    lcsg_checker chk (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .errors, .pending
    );

    // output side: random stall after each accepted result, none while quiet
    always @(posedge aclk) begin
        int nxt;
        nxt = sink_hold;
        if (sink_hold > 0)
            nxt = sink_hold - 1;
        else if (m_valid && m_ready)
            nxt = quiet ? 0 : $urandom_range(0, 16);
        sink_hold <= nxt;
        m_ready <= (nxt == 0);
    end

    // one request, after a random gap
    task automatic send_req(input logic [1:0] kind, input logic [2:0] idx,
                            input logic [31:0] stp, input logic [15:0] gain);
        int gap;
        lcsg_in_t r;
        gap = quiet ? 0 : $urandom_range(0, 16);
        r.kind = kind;
        r.point_index = idx;
        r.point_step = stp;
        r.point_gain = gain;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic tick();
        send_req(KIND_TICK, 3'($urandom), $urandom, 16'($urandom));
    endtask

    // stop sending and wait until all outputs have come and the block is idle
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (200) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] edge_or_rand();
        case ($urandom_range(0, 4))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // ascending breakpoint table spread over the whole step range
    task automatic load_table();
        for (int i = 0; i < 8; i++)
            send_req(KIND_POINT, i[2:0], (i << 29) + $urandom_range(0, 32'h1FFF_FFFF),
                     16'($urandom_range(0, 40000)));
    endtask

    initial begin
        int n, sel;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: finished sweep at reset values, ignored kind, table edges
        tick();
        send_req(2'd3, 3'd7, 32'hFFFF_FFFF, 16'hFFFF);
        send_req(KIND_POINT, 3'd0, 32'h0000_0000, 16'd0);
        send_req(KIND_POINT, 3'd1, 32'h0010_0000, 16'hFFFF);
        send_req(KIND_POINT, 3'd2, 32'h0040_0000, 16'd32768);
        send_req(KIND_POINT, 3'd3, 32'h0080_0000, 16'd100);
        send_req(KIND_POINT, 3'd4, 32'h0060_0000, 16'd20000);
        send_req(KIND_POINT, 3'd5, 32'h4000_0000, 16'd32767);
        send_req(KIND_POINT, 3'd6, 32'h8000_0000, 16'd1);
        send_req(KIND_POINT, 3'd7, 32'hFFFF_FFFF, 16'd5000);
        drain();
        reg_write(REG_START_STEP, 32'h0000_0000);
        reg_write(REG_STEP_DELTA, 32'h0018_0000);
        reg_write(REG_TOTAL_SAMPLES, 32'd6);
        reg_write(REG_FADE_SAMPLES, 32'd0);
        reg_write(REG_CHANNEL_COUNT, 32'd8);
        reg_write(REG_POINT_COUNT, 32'd8);
        send_req(KIND_RESTART, 3'd0, 32'd0, 16'd0);
        tick();
        tick();
        drain();
        reg_write(REG_SAMPLE_FORMAT, {30'd0, FMT_U8});
        tick();
        drain();
        reg_write(REG_SAMPLE_FORMAT, {30'd0, FMT_S32});
        tick();
        drain();
        reg_write(REG_SAMPLE_FORMAT, 32'd3);
        reg_write(REG_CHANNEL_COUNT, 32'd15);
        tick();
        tick();
        tick();
        drain();

        // random phases, each with its own register setting
        for (int ph = 0; ph < 14; ph++) begin
            quiet = (ph % 4 == 3);
            reg_write(REG_START_STEP, edge_or_rand());
            reg_write(REG_STEP_DELTA, edge_or_rand());
            case (ph % 5)
                0:       reg_write(REG_TOTAL_SAMPLES, 32'hFFFF_FFFF);
                1:       reg_write(REG_TOTAL_SAMPLES, 32'd0);
                default: reg_write(REG_TOTAL_SAMPLES, $urandom_range(1, 40));
            endcase
            case (ph % 4)
                0:       reg_write(REG_FADE_SAMPLES, 32'd0);
                1:       reg_write(REG_FADE_SAMPLES, 32'h00FF_FFFF);
                default: reg_write(REG_FADE_SAMPLES, $urandom_range(1, 12));
            endcase
            reg_write(REG_SAMPLE_FORMAT, $urandom_range(0, 3));
            reg_write(REG_CHANNEL_COUNT, (ph < 2) ? ph * 15 : $urandom_range(0, 15));
            reg_write(REG_POINT_COUNT, (ph % 3 == 0) ? 32'hF : $urandom_range(0, 15));
            if (ph % 2 == 0)
                load_table();
            send_req(KIND_RESTART, 3'($urandom), $urandom, 16'($urandom));
            n = 0;
            while (n < 24) begin
                sel = $urandom_range(0, 99);
                if (sel < 75) begin
                    tick();
                    n++;
                end else if (sel < 88) begin
                    send_req(KIND_POINT, 3'($urandom), edge_or_rand(), 16'($urandom));
                    n++;
                end else if (sel < 96) begin
                    send_req(KIND_RESTART, 3'($urandom), $urandom, 16'($urandom));
                    n++;
                end else begin
                    send_req(2'd3, 3'($urandom), $urandom, 16'($urandom));
                end
            end
            drain();
        end

        if (errors == 0 && pending == 0) begin
            $display("PASS linear_chirp_sample_generator_unit");
        end else begin
            $display("FAIL linear_chirp_sample_generator_unit");
        end
        $finish;
    end

    // watchdog
    initial begin
        #8_000_000;
        $display("FAIL linear_chirp_sample_generator_unit");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/lcsg_pkg.sv
sv/lcsg_mul.sv
sv/lcsg_div.sv
sv/linear_chirp_sample_generator_unit.sv
tb/lcsg_checker.sv
tb/tb.sv
